@@ hdl/pcc_pkg.sv @@
// ---------------------------------------------------------------------------
// Pivoted partial Cholesky package
// Shared widths, codes and the control types between the sequencer and the
// iterative square root and divide unit.
// ---------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  // Number format and matrix geometry.
  localparam int DW     = 32;
  localparam int FRAC   = 16;
  localparam int DIM_W  = 3;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 2 * DIM_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int MAX_DIM = 1 << DIM_W;
  localparam int TRACE_W = DW + DIM_W + 1;
  localparam int RAD_W  = DW + FRAC;
  localparam int ROOT_W = RAD_W / 2;
  localparam int ITER_W = 6;

  // Configuration register indexes.
  localparam logic CFG_SIZE_IN_USE = 1'b0;
  localparam logic CFG_TOL_SHIFT   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_LOAD_PIV = 2'd1,
    OP_START    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FULL_RANK = 2'd0,
    ST_NEAR_ZERO = 2'd1,
    ST_NOT_PD    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_TRACE_RD,
    S_TRACE_ACC,
    S_EPS,
    S_COL,
    S_DOT_LD,
    S_DOT_LOOP,
    S_DOT_MUL,
    S_DOT_SUB,
    S_PIV_CHECK,
    S_SQRT_WAIT,
    S_ROW,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef enum logic {
    UNIT_SQRT = 1'b0,
    UNIT_DIV  = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t mode;
  } unit_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] result;
  } unit_rsp_t;

endpackage

`default_nettype wire

@@ hdl/pcc_arith.sv @@
// ---------------------------------------------------------------------------
// Iterative square root and divide unit
// Square root of num * 2^FRAC one result bit per cycle, or the quotient
// (num * 2^FRAC) / den one bit per cycle, truncated and saturated.
// ---------------------------------------------------------------------------
`default_nettype none

module pcc_arith (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pcc_pkg::unit_req_t           req,
  input  wire logic signed [pcc_pkg::DW-1:0] num,
  input  wire logic [pcc_pkg::DW-1:0]       den,
  output pcc_pkg::unit_rsp_t                rsp
);
  import pcc_pkg::*;

  logic              busy;
  logic              done;
  unit_op_t          mode;
  logic [ITER_W-1:0] cnt;
  logic [RAD_W-1:0]  rad;
  logic [DW-1:0]     rem;
  logic [RAD_W-1:0]  quo;
  logic [ROOT_W-1:0] root;
  logic              neg;
  logic [DW-1:0]     dvs;

  logic [DW-1:0]       num_mag;
  logic [ITER_W-1:0]   bit_idx;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic [DW:0]         rem_sh;
  logic [DW:0]         lim;
  logic [DW:0]         quo_sat;
  logic [DW:0]         quo_signed;

  assign num_mag  = num[DW-1] ? DW'(-num) : DW'(num);
  assign bit_idx  = cnt - ITER_W'(1);
  assign trial    = root | (ROOT_W'(1) << bit_idx);
  assign trial_sq = trial * trial;
  assign rem_sh   = {rem, rad[RAD_W-1]};

  // Saturate the quotient magnitude to the signed range, then apply the sign.
  assign lim        = {1'b0, neg, {(DW-1){~neg}}};
  assign quo_sat    = (quo > {{(RAD_W-DW-1){1'b0}}, lim}) ? lim : quo[DW:0];
  assign quo_signed = neg ? -quo_sat : quo_sat;

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.mode == UNIT_SQRT) ? ITER_W'(ROOT_W) : ITER_W'(RAD_W);
      end else if (busy) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one root bit or one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      neg  <= num[DW-1];
      dvs  <= den;
      rem  <= '0;
      quo  <= '0;
      root <= '0;
      rad  <= {num_mag, {FRAC{1'b0}}};
    end else if (busy) begin
      if (mode == UNIT_SQRT) begin
        if (trial_sq <= rad) begin
          root <= trial;
        end
      end else begin
        rad <= rad << 1;
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= DW'(rem_sh - {1'b0, dvs});
          quo <= {quo[RAD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          quo <= {quo[RAD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (mode == UNIT_SQRT) ? $signed(DW'(root)) : $signed(quo_signed[DW-1:0]);

endmodule

`default_nettype wire

@@ hdl/pivoted_partial_cholesky.sv @@
// ---------------------------------------------------------------------------
// Pivoted partial Cholesky factorization
// Loads a symmetric Q16.16 matrix and a pivot list, factors it column by
// column in pivot order, and returns factor entries on request.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: op; tdata: row, col, value, order_pos,
//                       order_row, column_count
//  m_axis    out        tdata: status, rank, factor_value
//  cfg       in         write enable, register index, write data
//
// A load is written while the sequencer stays idle. A read passes through
// S_READ before its result is registered, and the next transaction waits
// until the sequencer is idle again. A start's run time is dominated by the
// 48-step divider and the 24-step square root. Reset is synchronous; the
// matrix and factor memories need no clearing. A new transaction is taken
// only when the sequencer is idle and the output register is empty or
// being emptied.
// ---------------------------------------------------------------------------
`default_nettype none

module pivoted_partial_cholesky (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] row, [5:3] col, [37:6] value, [40:38] order_pos,
  // [43:41] order_row, [47:44] column_count
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [5:2] rank, [37:6] factor_value, [39:38] zero
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_wdata
);
  import pcc_pkg::*;

  // Input fields.
  logic [DIM_W-1:0]     in_row;
  logic [DIM_W-1:0]     in_col;
  logic signed [DW-1:0] in_value;
  logic [DIM_W-1:0]     in_pos;
  logic [DIM_W-1:0]     in_prow;
  logic [CNT_W-1:0]     in_cc;
  op_t                  in_op;
  logic                 in_acc;

  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[5:3];
  assign in_value = s_axis_tdata[37:6];
  assign in_pos   = s_axis_tdata[40:38];
  assign in_prow  = s_axis_tdata[43:41];
  assign in_cc    = s_axis_tdata[47:44];
  assign in_op    = op_t'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  logic [CNT_W-1:0] size_in_use;
  logic [5:0]       tol_shift;
  logic [CNT_W-1:0] n_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= CNT_W'(MAX_DIM);
      tol_shift   <= 6'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_IN_USE: size_in_use <= cfg_wdata[CNT_W-1:0];
        CFG_TOL_SHIFT:   tol_shift   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_in_use == '0) begin
      n_dim = CNT_W'(1);
    end else if (size_in_use > CNT_W'(MAX_DIM)) begin
      n_dim = CNT_W'(MAX_DIM);
    end else begin
      n_dim = size_in_use;
    end
  end

  // Sequencer state and datapath registers.
  state_t                   state, state_next;
  logic [DIM_W-1:0]         order_store [MAX_DIM];
  logic [MAX_DIM-1:0]       handled;
  logic [CNT_W-1:0]         rank_reg;
  status_t                  status_reg;
  logic [CNT_W-1:0]         cc;
  logic [CNT_W-1:0]         col_i;
  logic [CNT_W-1:0]         k;
  logic [DIM_W-1:0]         l;
  logic [DIM_W-1:0]         j;
  logic [DIM_W-1:0]         rr;
  logic                     piv;
  logic signed [DW-1:0]     t;
  logic [DW-1:0]            p;
  logic signed [TRACE_W-1:0] trace;
  logic signed [TRACE_W-1:0] eps;
  logic [2*DW-1:0]          prod;
  logic                     prod_neg;
  logic                     rd_ok;
  logic                     m_valid;
  logic [39:0]              m_data;

  // Memories with registered read data.
  logic [DW-1:0]     matrix_mem [DEPTH];
  logic [DW-1:0]     factor_mem [DEPTH];
  logic [DW-1:0]     mat_q;
  logic [DW-1:0]     fa_q;
  logic [DW-1:0]     fb_q;
  logic [ADDR_W-1:0] mat_raddr;
  logic [ADDR_W-1:0] fa_addr;
  logic [ADDR_W-1:0] fb_addr;
  logic              fact_we;
  logic [ADDR_W-1:0] fact_waddr;
  logic [DW-1:0]     fact_wdata;

  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  // Decisions taken in several places.
  logic [DIM_W-1:0]          j_c;
  logic                      j_bad;
  logic signed [TRACE_W-1:0] t_ext;
  logic                      near_zero;
  logic                      row_end;
  logic                      row_skip;
  logic                      dot_end;
  logic signed [DW-1:0]      t_sub;

  assign j_c       = order_store[col_i[DIM_W-1:0]];
  assign j_bad     = {1'b0, j_c} >= n_dim;
  assign t_ext     = TRACE_W'(t);
  assign near_zero = (t_ext < eps) && (t_ext > -eps);
  assign row_end   = k == n_dim;
  assign row_skip  = (k[DIM_W-1:0] == j) || handled[k[DIM_W-1:0]];
  assign dot_end   = l == col_i[DIM_W-1:0];

  // Finish a Q16.16 product and subtract it from t, both saturating.
  function automatic logic signed [DW-1:0] mul_sub(
    logic signed [DW-1:0] a, logic [2*DW-1:0] pr, logic ng);
    logic [2*DW-FRAC-1:0] sh;
    logic [DW:0]          lim;
    logic [DW:0]          m;
    logic [DW:0]          v;
    logic signed [DW+1:0] d;
    sh  = pr[2*DW-1:FRAC];
    lim = {1'b0, ng, {(DW-1){~ng}}};
    m   = (sh > {{(DW-FRAC-1){1'b0}}, lim}) ? lim : sh[DW:0];
    v   = ng ? -m : m;
    d   = {{2{a[DW-1]}}, a} - {v[DW], v};
    if (d[DW+1:DW-1] == 3'b000 || d[DW+1:DW-1] == 3'b111) begin
      return d[DW-1:0];
    end else if (d[DW+1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  assign t_sub = mul_sub(t, prod, prod_neg);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_START: state_next = S_TRACE_RD;
            OP_READ:  state_next = S_READ;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_READ:      state_next = S_IDLE;
      S_TRACE_RD:  state_next = S_TRACE_ACC;
      S_TRACE_ACC: state_next = (k == n_dim - CNT_W'(1)) ? S_EPS : S_TRACE_RD;
      S_EPS:       state_next = S_COL;
      S_COL: begin
        if (col_i == cc || j_bad) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DOT_LD;
        end
      end
      S_DOT_LD:    state_next = S_DOT_LOOP;
      S_DOT_LOOP: begin
        if (dot_end) begin
          state_next = piv ? S_PIV_CHECK : S_DIV_WAIT;
        end else begin
          state_next = S_DOT_MUL;
        end
      end
      S_DOT_MUL:   state_next = S_DOT_SUB;
      S_DOT_SUB:   state_next = S_DOT_LOOP;
      S_PIV_CHECK: state_next = (near_zero || t < 0) ? S_DONE : S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (unit_rsp.done) begin
          state_next = (unit_rsp.result == '0) ? S_DONE : S_ROW;
        end
      end
      S_ROW: begin
        if (row_end) begin
          state_next = S_COL;
        end else if (!row_skip) begin
          state_next = S_DOT_LD;
        end
      end
      S_DIV_WAIT:  state_next = unit_rsp.done ? S_ROW : S_DIV_WAIT;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Memory addresses, factor writes and unit requests.
  always_comb begin
    mat_raddr     = '0;
    fa_addr       = {rr, l};
    fb_addr       = {j, l};
    fact_we       = 1'b0;
    fact_waddr    = {k[DIM_W-1:0], col_i[DIM_W-1:0]};
    fact_wdata    = '0;
    unit_req      = '{start: 1'b0, mode: UNIT_SQRT};
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        fa_addr       = {in_row, in_col};
        s_axis_tready = !m_valid || m_axis_tready;
      end
      S_TRACE_RD: mat_raddr = {k[DIM_W-1:0], k[DIM_W-1:0]};
      S_COL:      mat_raddr = {j_c, j_c};
      S_ROW: begin
        mat_raddr = {k[DIM_W-1:0], j};
        if (!row_end && (k[DIM_W-1:0] != j) && handled[k[DIM_W-1:0]]) begin
          fact_we = 1'b1;
        end
      end
      S_DOT_LOOP: begin
        if (dot_end && !piv) begin
          unit_req = '{start: 1'b1, mode: UNIT_DIV};
        end
      end
      S_PIV_CHECK: begin
        if (!near_zero && t >= 0) begin
          unit_req = '{start: 1'b1, mode: UNIT_SQRT};
        end
      end
      S_SQRT_WAIT: begin
        fact_waddr = {j, col_i[DIM_W-1:0]};
        fact_wdata = unit_rsp.result;
        fact_we    = unit_rsp.done && (unit_rsp.result != '0);
      end
      S_DIV_WAIT: begin
        fact_wdata = unit_rsp.result;
        fact_we    = unit_rsp.done;
      end
      default: ;
    endcase
  end

  // Matrix memory: loads write, the sequencer reads.
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_LOAD_MAT) begin
      matrix_mem[{in_row, in_col}] <= in_value;
    end
    mat_q <= matrix_mem[mat_raddr];
  end

  // Factor memory: one write port, two read ports. Reads during a column
  // touch only earlier columns, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (fact_we) begin
      factor_mem[fact_waddr] <= fact_wdata;
    end
    fa_q <= factor_mem[fa_addr];
    fb_q <= factor_mem[fb_addr];
  end

  // Pivot list.
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_LOAD_PIV) begin
      order_store[in_pos] <= in_prow;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      handled    <= '0;
      rank_reg   <= '0;
      status_reg <= ST_FULL_RANK;
    end else begin
      state <= state_next;
      case (state)
        S_EPS: begin
          handled    <= '0;
          rank_reg   <= '0;
          status_reg <= ST_FULL_RANK;
        end
        S_COL: begin
          if (col_i != cc && j_bad) begin
            status_reg <= ST_NOT_PD;
          end
        end
        S_PIV_CHECK: begin
          if (near_zero) begin
            status_reg <= ST_NEAR_ZERO;
          end else if (t < 0) begin
            status_reg <= ST_NOT_PD;
          end
        end
        S_SQRT_WAIT: begin
          if (unit_rsp.done) begin
            if (unit_rsp.result == '0) begin
              status_reg <= ST_NEAR_ZERO;
            end else begin
              handled[j] <= 1'b1;
            end
          end
        end
        S_ROW: begin
          if (row_end) begin
            rank_reg <= col_i + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k     <= '0;
        trace <= '0;
        cc    <= (in_cc > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : in_cc;
        rd_ok <= ({1'b0, in_row} < n_dim) && ({1'b0, in_col} < rank_reg);
      end
      S_TRACE_ACC: begin
        trace <= trace + TRACE_W'($signed(mat_q));
        k     <= k + CNT_W'(1);
      end
      S_EPS: begin
        eps   <= (trace > 0) ? (trace >> tol_shift) : '0;
        col_i <= '0;
      end
      S_COL: begin
        j   <= j_c;
        rr  <= j_c;
        piv <= 1'b1;
        l   <= '0;
      end
      S_DOT_LD:  t <= mat_q;
      S_DOT_MUL: begin
        prod     <= (fa_q[DW-1] ? DW'(-fa_q) : fa_q) * (fb_q[DW-1] ? DW'(-fb_q) : fb_q);
        prod_neg <= fa_q[DW-1] ^ fb_q[DW-1];
      end
      S_DOT_SUB: begin
        t <= t_sub;
        l <= l + DIM_W'(1);
      end
      S_SQRT_WAIT: begin
        p <= unit_rsp.result;
        k <= '0;
      end
      S_ROW: begin
        if (row_end) begin
          col_i <= col_i + CNT_W'(1);
        end else if (row_skip) begin
          k <= k + CNT_W'(1);
        end else begin
          rr  <= k[DIM_W-1:0];
          piv <= 1'b0;
          l   <= '0;
        end
      end
      S_DIV_WAIT: begin
        if (unit_rsp.done) begin
          k <= k + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  pcc_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (unit_req),
    .num (t),
    .den (p),
    .rsp (unit_rsp)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (state == S_READ || state == S_DONE) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      m_data <= {2'b00, (rd_ok ? fa_q : {DW{1'b0}}), rank_reg, status_reg};
    end else if (state == S_DONE) begin
      m_data <= {2'b00, {DW{1'b0}}, rank_reg, status_reg};
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  // A transaction is only taken while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE)
    else $error("input taken outside idle");

  // Factor writes stay inside the active dimension.
  a_write_row: assert property (@(posedge clk) disable iff (rst)
    fact_we |-> {1'b0, fact_waddr[ADDR_W-1:DIM_W]} < n_dim)
    else $error("factor write beyond dimension");

  // A start transaction begins the trace pass.
  a_start_trace: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_op == OP_START) |=> state == S_TRACE_RD)
    else $error("start did not begin trace");

  // A result appears only after a read or the end of a factorization.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_READ || $past(state) == S_DONE))
    else $error("unexpected result");

endmodule

`default_nettype wire

@@ dv/pivoted_partial_cholesky_test.sv @@
// ---------------------------------------------------------------------------
// Pivoted partial Cholesky testbench
// Streams matrix loads, pivot lists, starts and factor reads into the block,
// predicts every result with a fixed-point model of the factorization and
// compares each output transaction field by field, under random idling on
// both sides and over several dimension and tolerance settings.
// ---------------------------------------------------------------------------
`default_nettype none

module pivoted_partial_cholesky_test;
  import pcc_pkg::*;

  typedef struct {
    op_t         op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic [2:0]  pos;
    logic [2:0]  prow;
    logic [3:0]  cc;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  rank;
    logic [31:0] fval;
  } answer_t;

  // Fixed-point model of the factorization and store of expected answers.
  class chol_scoreboard;
    longint  mat[8][8];
    longint  fac[8][8];
    int      piv[8];
    bit      used_row[8];
    int      cur_rank;
    int      cur_status;
    int      dim_reg = 8;
    int      shift_reg = 33;
    answer_t awaited[$];
    int      errors;
    int      checked;
    int      starts;
    int      reads;
    int      status_seen[3];

    function longint clamp_mag(bit neg, logic [63:0] m);
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint fx_mul(longint a, longint b);
      return clamp_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> FRAC);
    endfunction

    function longint fx_sub(longint a, longint b);
      longint r;
      r = a - b;
      if (r > 64'sh7fff_ffff) r = 64'sh7fff_ffff;
      if (r < -64'sh8000_0000) r = -64'sh8000_0000;
      return r;
    endfunction

    function longint fx_sqrt(longint v);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] c;
      x = 64'(v) << FRAC;
      res = 0;
      for (int b = 30; b >= 0; b--) begin
        c = res | (64'd1 << b);
        if (c * c <= x) res = c;
      end
      return clamp_mag(1'b0, res);
    endfunction

    function longint fx_div(longint num, longint den);
      return clamp_mag((num < 0) != (den < 0), (mag(num) << FRAC) / mag(den));
    endfunction

    function void set_reg(logic idx, int v);
      if (idx == CFG_SIZE_IN_USE) dim_reg = v & 15;
      else shift_reg = v & 63;
    endfunction

    function int dim();
      if (dim_reg == 0) return 1;
      return dim_reg > 8 ? 8 : dim_reg;
    endfunction

    function void factorize(int cc);
      int     n;
      int     j;
      longint tr;
      longint eps;
      longint t;
      longint p;
      n = dim();
      tr = 0;
      for (int k = 0; k < n; k++) tr += mat[k][k];
      eps = tr > 0 ? tr >>> shift_reg : 0;
      for (int k = 0; k < 8; k++) used_row[k] = 0;
      cur_rank = 0;
      cur_status = ST_FULL_RANK;
      if (cc > 8) cc = 8;
      for (int i = 0; i < cc; i++) begin
        j = piv[i];
        if (j >= n) begin
          cur_status = ST_NOT_PD;
          return;
        end
        t = mat[j][j];
        for (int k = 0; k < i; k++) t = fx_sub(t, fx_mul(fac[j][k], fac[j][k]));
        if (t < eps && t > -eps) begin
          cur_status = ST_NEAR_ZERO;
          return;
        end
        if (t < 0) begin
          cur_status = ST_NOT_PD;
          return;
        end
        p = fx_sqrt(t);
        if (p == 0) begin
          cur_status = ST_NEAR_ZERO;
          return;
        end
        fac[j][i] = p;
        used_row[j] = 1;
        for (int k = 0; k < n; k++) begin
          if (k != j) begin
            if (used_row[k]) begin
              fac[k][i] = 0;
            end else begin
              t = mat[k][j];
              for (int l = 0; l < i; l++) t = fx_sub(t, fx_mul(fac[k][l], fac[j][l]));
              fac[k][i] = fx_div(t, p);
            end
          end
        end
        cur_rank = i + 1;
      end
    endfunction

    // Notes an accepted input transaction and, for a start or a read, queues its expected answer.
    function void note_input(cmd_t c);
      answer_t a;
      a.fval = 0;
      case (c.op)
        OP_LOAD_MAT: mat[c.row][c.col] = longint'($signed(c.value));
        OP_LOAD_PIV: piv[c.pos] = c.prow;
        OP_START: begin
          factorize(c.cc);
          starts++;
          status_seen[cur_status]++;
        end
        default: begin
          reads++;
          if (c.row < dim() && c.col < cur_rank) a.fval = 32'(fac[c.row][c.col]);
        end
      endcase
      if (c.op == OP_START || c.op == OP_READ) begin
        a.status = 2'(cur_status);
        a.rank = 4'(cur_rank);
        awaited.push_back(a);
      end
    endfunction

    // Checks one output transaction against the oldest expectation.
    function void check_result(logic [39:0] d);
      answer_t a;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      a = awaited.pop_front();
      checked++;
      if (d[1:0] !== a.status) begin
        $display("%0t: status expected %0d actual %0d", $time, a.status, d[1:0]);
        errors++;
      end
      if (d[5:2] !== a.rank) begin
        $display("%0t: rank expected %0d actual %0d", $time, a.rank, d[5:2]);
        errors++;
      end
      if (d[37:6] !== a.fval) begin
        $display("%0t: factor expected %h actual %h", $time, a.fval, d[37:6]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  chol_scoreboard sb = new();
  int burst_left;
  int sent;
  int idle_cycles;
  int stall_mode;
  int stall_count;

  pivoted_partial_cholesky i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Receiver stalls follow a random mode (always, half or rarely ready) that is chosen anew at random intervals.
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_count = $urandom_range(50, 400);
    end
    stall_count--;
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      default: m_axis_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // Result checking and the watchdog on stalled handshakes.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= 80000) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.awaited.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one input transaction, opening a random gap between bursts.
  task automatic send(cmd_t c);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = c.op;
    s_axis_tdata = {c.cc, c.prow, c.pos, c.value, c.col, c.row};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(c);
    sent++;
  endtask

  task automatic send_op(op_t op, int row, int col, logic [31:0] value,
                         int pos, int prow, int cc);
    cmd_t c;
    c.op = op;
    c.row = 3'(row);
    c.col = 3'(col);
    c.value = value;
    c.pos = 3'(pos);
    c.prow = 3'(prow);
    c.cc = 4'(cc);
    send(c);
  endtask

  // Waits for every expected result, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = 6'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Loads a symmetric, mostly diagonally dominant matrix of the active size,
  // a pivot permutation, starts a factorization and reads entries back.
  task automatic factor_run();
    int n;
    int ord[8];
    int tmp;
    int k;
    logic [31:0] v;
    n = sb.dim();
    for (int r = 0; r < n; r++) begin
      for (int c = r; c < n; c++) begin
        if (r == c) v = 32'(n * 32'h2_0000 + $urandom_range(0, 32'h2_0000));
        else v = 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
        case ($urandom_range(0, 15))
          0: if (r == c) v = $urandom_range(0, 3);
          1: if (r == c) v = -$urandom_range(1, 32'h1_0000);
          2: v = $urandom;
          default: ;
        endcase
        send_op(OP_LOAD_MAT, r, c, v, 0, 0, 0);
        if (r != c) send_op(OP_LOAD_MAT, c, r, v, 0, 0, 0);
      end
    end
    for (int i = 0; i < 8; i++) ord[i] = i % n;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = ord[i];
      ord[i] = ord[k];
      ord[k] = tmp;
    end
    if ($urandom_range(0, 9) == 0) ord[$urandom_range(0, 7)] = $urandom_range(0, 7);
    for (int i = 0; i < 8; i++) send_op(OP_LOAD_PIV, 0, 0, 0, i, ord[i], 0);
    send_op(OP_START, 0, 0, 0, 0, 0,
            $urandom_range(0, 5) == 0 ? $urandom_range(0, 15) : n);
    repeat ($urandom_range(4, 12))
      send_op(OP_READ, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
              $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 15));
  endtask

  // Random noise: any operation with any field values.
  task automatic noise_item();
    cmd_t c;
    c.op = op_t'($urandom_range(0, 3));
    c.row = 3'($urandom);
    c.col = 3'($urandom);
    c.value = $urandom;
    c.pos = 3'($urandom);
    c.prow = 3'($urandom);
    c.cc = 4'($urandom);
    send(c);
  endtask

  int sizes[8] = '{8, 1, 4, 0, 12, 8, 5, 3};
  int shifts[8] = '{33, 0, 63, 10, 20, 0, 33, 40};

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every store entry gets a value before anything reads it.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send_op(OP_LOAD_MAT, r, c, (r == c) ? 32'h0008_0000 : 32'h0000_4000, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_op(OP_LOAD_PIV, 0, 0, 0, i, 7 - i, 0);

    // Directed: reads before any start, full and empty column counts,
    // extreme values, a pivot out of range and a zero pivot.
    send_op(OP_READ, 7, 7, 0, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 15);
    send_op(OP_READ, 0, 0, 0, 0, 0, 0);
    send_op(OP_READ, 7, 7, 0, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 0);
    send_op(OP_LOAD_MAT, 3, 3, 32'h7fff_ffff, 0, 0, 0);
    send_op(OP_LOAD_MAT, 2, 5, 32'h8000_0000, 0, 0, 0);
    send_op(OP_LOAD_MAT, 5, 2, 32'h8000_0000, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 8);
    send_op(OP_READ, 5, 1, 0, 0, 0, 0);
    send_op(OP_LOAD_MAT, 4, 4, 32'hffff_0000, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 8);
    send_op(OP_LOAD_MAT, 4, 4, 32'h0000_0000, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 8);
    drain();
    write_reg(CFG_SIZE_IN_USE, 3);
    write_reg(CFG_TOL_SHIFT, 63);
    send_op(OP_START, 0, 0, 0, 0, 0, 2);
    send_op(OP_LOAD_PIV, 0, 0, 0, 0, 0, 0);
    send_op(OP_LOAD_MAT, 0, 0, 32'h0000_0001, 0, 0, 0);
    send_op(OP_START, 0, 0, 0, 0, 0, 1);
    send_op(OP_READ, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SIZE_IN_USE, sizes[ph]);
      write_reg(CFG_TOL_SHIFT, shifts[ph]);
      while (sent < 80 + (ph + 1) * 120) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 10)) noise_item();
        else factor_run();
      end
      drain();
    end

    $display("Checked %0d results from %0d starts and %0d reads over %0d inputs.",
             sb.checked, sb.starts, sb.reads, sent);
    $display("Start outcomes: %0d full rank, %0d near zero, %0d not positive definite.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/pcc_pkg.sv
hdl/pcc_arith.sv
hdl/pivoted_partial_cholesky.sv
dv/pivoted_partial_cholesky_test.sv
